// ===== design/wheel_encoder_odometry_counter_defines.svh =====
// assertion macros shared by the odometry counter modules
// no dependencies; included by the files that carry assertions
`ifndef WHEEL_ENCODER_ODOMETRY_COUNTER_DEFINES_SVH
`define WHEEL_ENCODER_ODOMETRY_COUNTER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define WHEO_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("wheo assertion failed");

// antecedent implies consequent in the next cycle
`define WHEO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("wheo assertion failed");

`endif

// ===== design/wheo_pkg.sv =====
// shared constants, codes and command/status types for the odometry counter
// no dependencies
package wheo_pkg;

	localparam int NUM_WHEELS = 2;

	localparam int FREQ_W  = 24;
	localparam int CPCM_W  = 15;
	localparam int DELTA_W = 16;
	localparam int PER_W   = 24;
	localparam int SPEED_W = 25;
	localparam int VALUE_W = 16;
	localparam int TOTAL_W = 32;
	localparam int CM_W    = 16;
	localparam int CFG_W   = 24;
	localparam int CNT_W   = $clog2(PER_W);

	localparam logic [FREQ_W-1:0] FREQ_RESET = 24'd156006;
	localparam logic [CPCM_W-1:0] CPCM_RESET = 15'd112;

	typedef logic [1:0] op_code_t;
	localparam op_code_t OP_ACCUMULATE = 2'd0;
	localparam op_code_t OP_SPEED      = 2'd1;
	localparam op_code_t OP_READ       = 2'd2;

	typedef logic [1:0] read_mode_t;
	localparam read_mode_t RD_TOTAL   = 2'd0;
	localparam read_mode_t RD_CM      = 2'd1;
	localparam read_mode_t RD_PARTIAL = 2'd2;

	typedef logic [1:0] reg_index_t;
	localparam reg_index_t REG_TIMER_FREQ = 2'd0;
	localparam reg_index_t REG_CPCM_LEFT  = 2'd1;
	localparam reg_index_t REG_CPCM_RIGHT = 2'd2;

	localparam logic KIND_SPEED = 1'b0;
	localparam logic KIND_READ  = 1'b1;

	typedef struct packed {
		logic load;        // capture the input beat and seed the divider
		logic acc_add;     // form the new totals
		logic acc_commit;  // compare against counts per cm and write back
		logic div_step;    // one restoring division step
		logic read_exec;   // pick the read value and clear the source
		logic out_load;    // move the result into the output register
	} cmd_t;

	typedef struct packed {
		logic div_last;
	} status_t;

endpackage

// ===== design/wheo_ctrl.sv =====
// controller state machine for the odometry counter
// depends on wheo_pkg and wheel_encoder_odometry_counter_defines.svh
`include "wheel_encoder_odometry_counter_defines.svh"

module wheo_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  wheo_pkg::op_code_t in_op,
	output logic              out_valid,
	input  logic              out_ready,
	input  wheo_pkg::status_t status,
	output wheo_pkg::cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC_ADD,
		ST_ACC_COMMIT,
		ST_DIV,
		ST_READ,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd            = '0;
		cmd.load       = accept;
		cmd.acc_add    = (state_q == ST_ACC_ADD);
		cmd.acc_commit = (state_q == ST_ACC_COMMIT);
		cmd.div_step   = (state_q == ST_DIV);
		cmd.read_exec  = (state_q == ST_READ);
		cmd.out_load   = (state_q == ST_FINISH) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (in_op)
							wheo_pkg::OP_ACCUMULATE: state_q <= ST_ACC_ADD;
							wheo_pkg::OP_SPEED:      state_q <= ST_DIV;
							wheo_pkg::OP_READ:       state_q <= ST_READ;
							default:                 state_q <= ST_IDLE;
						endcase
					end
				end
				ST_ACC_ADD:    state_q <= ST_ACC_COMMIT;
				ST_ACC_COMMIT: state_q <= ST_IDLE;
				ST_DIV: begin
					if (status.div_last)
						state_q <= ST_FINISH;
				end
				ST_READ:       state_q <= ST_FINISH;
				ST_FINISH: begin
					if (!out_valid_q || out_ready)
						state_q <= ST_IDLE;
				end
				default:       state_q <= ST_IDLE;
			endcase
		end
	end

	`WHEO_ASSERT_SAME(a_load_free, clk, arst_n, cmd.out_load, !out_valid_q || out_ready)
	`WHEO_ASSERT_NEXT(a_load_shows, clk, arst_n, cmd.out_load, out_valid_q)
	`WHEO_ASSERT_NEXT(a_speed_divides, clk, arst_n, accept && in_op == wheo_pkg::OP_SPEED,
		state_q == ST_DIV)
	`WHEO_ASSERT_NEXT(a_div_ends, clk, arst_n, state_q == ST_DIV && status.div_last,
		state_q == ST_FINISH)

endmodule

// ===== design/wheo_datapath.sv =====
// datapath: configuration registers, per-wheel counters, serial divider, output register
// depends on wheo_pkg and wheel_encoder_odometry_counter_defines.svh
`include "wheel_encoder_odometry_counter_defines.svh"

module wheo_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  wheo_pkg::reg_index_t                 cfg_index,
	input  logic [wheo_pkg::CFG_W-1:0]           cfg_data,
	input  wheo_pkg::op_code_t                   in_op,
	input  logic                                 in_wheel,
	input  logic signed [wheo_pkg::DELTA_W-1:0]  in_delta,
	input  logic [wheo_pkg::PER_W-1:0]           in_period,
	input  logic                                 in_direction,
	input  wheo_pkg::read_mode_t                 in_read_mode,
	input  wheo_pkg::cmd_t                       cmd,
	output wheo_pkg::status_t                    status,
	output logic                                 out_kind,
	output logic signed [wheo_pkg::SPEED_W-1:0]  out_speed,
	output logic [wheo_pkg::VALUE_W-1:0]         out_value
);

	localparam int TW = wheo_pkg::TOTAL_W;

	// configuration
	logic [wheo_pkg::FREQ_W-1:0] timer_freq_q;
	logic [wheo_pkg::CPCM_W-1:0] cpcm_q [wheo_pkg::NUM_WHEELS];

	// captured beat
	wheo_pkg::op_code_t               op_q;
	logic                             wheel_q;
	logic signed [wheo_pkg::DELTA_W-1:0] delta_q;
	logic [wheo_pkg::PER_W-1:0]       period_q;
	logic                             dir_q;
	wheo_pkg::read_mode_t             mode_q;

	// wheel state
	logic [TW-1:0]              total_q   [wheo_pkg::NUM_WHEELS];
	logic [TW-1:0]              partial_q [wheo_pkg::NUM_WHEELS];
	logic [wheo_pkg::CM_W-1:0]  cm_q      [wheo_pkg::NUM_WHEELS];

	logic [TW-1:0] total_sum_q;
	logic [TW-1:0] partial_sum_q;

	// divider
	logic [wheo_pkg::PER_W:0]     rem_q;
	logic [wheo_pkg::FREQ_W-1:0]  quot_q;
	logic [wheo_pkg::CNT_W-1:0]   cnt_q;
	logic [wheo_pkg::PER_W:0]     rem_shift;
	logic [wheo_pkg::PER_W:0]     rem_diff;

	logic [wheo_pkg::VALUE_W-1:0] read_val_q;

	logic                       wheel_ok;
	logic [TW-1:0]              delta_ext;
	logic [wheo_pkg::CPCM_W-1:0] lim;
	logic signed [TW:0]         neg_chk;
	logic                       step_up;
	logic                       step_down;
	logic [wheo_pkg::SPEED_W-1:0] quot_ext;
	logic [wheo_pkg::SPEED_W-1:0] speed;

	assign wheel_ok  = (32'(wheel_q) < 32'(wheo_pkg::NUM_WHEELS));
	assign delta_ext = TW'(delta_q);
	assign lim       = cpcm_q[wheel_q];

	// partial + lim <= 0 is the same as partial <= -lim
	assign neg_chk   = $signed({partial_sum_q[TW-1], partial_sum_q})
		+ $signed({(TW - wheo_pkg::CPCM_W + 1)'(0), lim});
	assign step_up   = !partial_sum_q[TW-1] && (partial_sum_q != '0)
		&& (partial_sum_q >= TW'(lim));
	assign step_down = partial_sum_q[TW-1] && (neg_chk[TW] || (neg_chk == '0));

	assign rem_shift = {rem_q[wheo_pkg::PER_W-1:0], quot_q[wheo_pkg::FREQ_W-1]};
	assign rem_diff  = rem_shift - {1'b0, period_q};

	assign status.div_last = (cnt_q == wheo_pkg::CNT_W'(wheo_pkg::PER_W - 1));

	assign quot_ext = (period_q == '0) ? '0 : {1'b0, quot_q};
	assign speed    = dir_q ? quot_ext : (wheo_pkg::SPEED_W'(0) - quot_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_freq_q <= wheo_pkg::FREQ_RESET;
			for (int i = 0; i < wheo_pkg::NUM_WHEELS; i++) begin
				cpcm_q[i]    <= wheo_pkg::CPCM_RESET;
				total_q[i]   <= '0;
				partial_q[i] <= '0;
				cm_q[i]      <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					wheo_pkg::REG_TIMER_FREQ: timer_freq_q <= cfg_data;
					wheo_pkg::REG_CPCM_LEFT:  cpcm_q[0] <= cfg_data[wheo_pkg::CPCM_W-1:0];
					wheo_pkg::REG_CPCM_RIGHT: cpcm_q[1] <= cfg_data[wheo_pkg::CPCM_W-1:0];
					default: ;
				endcase
			end
			if (cmd.acc_commit && wheel_ok) begin
				total_q[wheel_q] <= total_sum_q;
				if (step_up) begin
					cm_q[wheel_q]      <= cm_q[wheel_q] + wheo_pkg::CM_W'(1);
					partial_q[wheel_q] <= '0;
				end else if (step_down) begin
					cm_q[wheel_q]      <= cm_q[wheel_q] - wheo_pkg::CM_W'(1);
					partial_q[wheel_q] <= '0;
				end else begin
					partial_q[wheel_q] <= partial_sum_q;
				end
			end
			if (cmd.read_exec && wheel_ok) begin
				case (mode_q)
					wheo_pkg::RD_CM:      cm_q[wheel_q] <= '0;
					wheo_pkg::RD_PARTIAL: partial_q[wheel_q] <= '0;
					default: ;
				endcase
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= in_op;
			wheel_q  <= in_wheel;
			delta_q  <= in_delta;
			period_q <= in_period;
			dir_q    <= in_direction;
			mode_q   <= in_read_mode;
			rem_q    <= '0;
			quot_q   <= timer_freq_q;
			cnt_q    <= '0;
		end else if (cmd.div_step) begin
			if (!rem_diff[wheo_pkg::PER_W]) begin
				rem_q  <= rem_diff;
				quot_q <= {quot_q[wheo_pkg::FREQ_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_shift;
				quot_q <= {quot_q[wheo_pkg::FREQ_W-2:0], 1'b0};
			end
			cnt_q <= cnt_q + wheo_pkg::CNT_W'(1);
		end
		if (cmd.acc_add) begin
			total_sum_q   <= total_q[wheel_q] + delta_ext;
			partial_sum_q <= partial_q[wheel_q] + delta_ext;
		end
		if (cmd.read_exec) begin
			if (wheel_ok) begin
				case (mode_q)
					wheo_pkg::RD_TOTAL:   read_val_q <= total_q[wheel_q][wheo_pkg::VALUE_W-1:0];
					wheo_pkg::RD_CM:      read_val_q <= cm_q[wheel_q];
					wheo_pkg::RD_PARTIAL:
						read_val_q <= partial_q[wheel_q][wheo_pkg::VALUE_W-1:0];
					default:              read_val_q <= '0;
				endcase
			end else begin
				read_val_q <= '0;
			end
		end
		if (cmd.out_load) begin
			if (op_q == wheo_pkg::OP_READ) begin
				out_kind  <= wheo_pkg::KIND_READ;
				out_speed <= '0;
				out_value <= read_val_q;
			end else begin
				out_kind  <= wheo_pkg::KIND_SPEED;
				out_speed <= $signed(speed);
				out_value <= '0;
			end
		end
	end

	`WHEO_ASSERT_NEXT(a_add_then_commit, clk, arst_n, cmd.acc_add, cmd.acc_commit)
	`WHEO_ASSERT_SAME(a_step_exclusive, clk, arst_n, cmd.acc_commit, !(step_up && step_down))
	`WHEO_ASSERT_NEXT(a_div_seeded, clk, arst_n, cmd.load, cnt_q == '0 && rem_q == '0)

endmodule

// ===== design/wheel_encoder_odometry_counter.sv =====
// Two-wheel odometry counter: pulse totals, centimetre counts and
// period-based speed from quadrature encoder data.
//
// Input stream (s_*): one beat per command. s_tuser carries the operation
// (accumulate, speed, read); s_tdata carries wheel, count delta, period,
// direction and read mode. Accumulate beats give no output beat.
// Output stream (m_*): speed and read results; m_tuser is the result kind.
// Configuration: cfg_we/cfg_index/cfg_data writes timer frequency (0)
// and counts per cm for left (1) and right (2) wheel, taken at once.
//
// Sequencing: the block takes one command at a time. An accumulate passes
// through an add and a commit state; a read passes through a read and a
// finish state, and its result then goes into the output register. A speed
// command runs a 24-step restoring divider, one quotient bit a cycle, and
// then a finish state; the divider sets the rate.
// The output register frees the input side: a new command is taken while
// a result still waits. If the receiver stalls and a second result is
// ready, the block holds that result and takes nothing more until the
// waiting beat leaves. Reset clears all counters, restores the
// configuration defaults and empties the output register.
// depends on wheo_pkg, wheo_ctrl, wheo_datapath

module wheel_encoder_odometry_counter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // wheel, count_delta, period, direction, read_mode, zero pad
	input  logic [1:0]  s_tuser,   // operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // wheel_speed, read_value, zero pad
	output logic        m_tuser,   // result_kind
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	wheo_pkg::cmd_t    cmd;
	wheo_pkg::status_t status;

	logic signed [wheo_pkg::SPEED_W-1:0] out_speed;
	logic [wheo_pkg::VALUE_W-1:0]        out_value;

	wheo_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_op     (s_tuser),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.status    (status),
		.cmd       (cmd)
	);

	wheo_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_op        (s_tuser),
		.in_wheel     (s_tdata[0]),
		.in_delta     ($signed(s_tdata[16:1])),
		.in_period    (s_tdata[40:17]),
		.in_direction (s_tdata[41]),
		.in_read_mode (s_tdata[43:42]),
		.cmd          (cmd),
		.status       (status),
		.out_kind     (m_tuser),
		.out_speed    (out_speed),
		.out_value    (out_value)
	);

	assign m_tdata = {7'b0, out_value, out_speed};

endmodule
